@@ rtl/core/cgf_pkg.sv @@
package cgf_pkg;

   // default number of fraction bits in positions, masses and forces
   localparam int FRAC_BITS_DEF = 16;

   // register map
   localparam logic [1:0] CSR_GRAV_CONSTANT = 2'd0;
   localparam logic [1:0] CSR_MIN_DIST_SQ   = 2'd1;
   localparam logic [1:0] CSR_MAX_DIST_SQ   = 2'd2;

   localparam int WORD_W  = 32;
   localparam int DIST_W  = 48;
   localparam int DIFF_W  = WORD_W + 1;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int MAG_W   = 64;
   localparam int ROOT_W  = SQ_W / 2;

   localparam logic [DIST_W-1:0] GRAV_RESET = DIST_W'(65536);
   localparam logic [DIST_W-1:0] MIN_RESET  = DIST_W'(65536);
   localparam logic [DIST_W-1:0] MAX_RESET  = {DIST_W{1'b1}};

   // travels alongside the magnitude division
   typedef struct packed {
      logic [SQ_W-1:0]   dist_sq;
      logic [DIFF_W-1:0] abs_x;
      logic [DIFF_W-1:0] abs_y;
      logic              neg_x;
      logic              neg_y;
      logic              zero;
      logic              sat;
      logic              mag_sat;
   } mdiv_side_type;

   // travels alongside the square root
   typedef struct packed {
      logic [MAG_W-1:0]  mag;
      logic [DIFF_W-1:0] abs_x;
      logic [DIFF_W-1:0] abs_y;
      logic              neg_x;
      logic              neg_y;
      logic              zero;
      logic              sat;
   } sqrt_side_type;

   // travels alongside the x unit division
   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             neg_x;
      logic             zero;
      logic             sat;
   } udiv_side_type;

endpackage

@@ rtl/core/cgf_div.sv @@
module cgf_div import cgf_pkg::*; #(
   parameter int DW = 48,
   parameter int QW = 64,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [DW-1:0] in_rem,
   input  logic [QW-1:0] in_num,
   input  logic [DW-1:0] in_div,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);

   logic          valid_ff [QW];
   logic [DW-1:0] rem_ff   [QW];
   logic [QW-1:0] num_ff   [QW];
   logic [DW-1:0] div_ff   [QW];
   logic [QW-1:0] quo_ff   [QW];
   logic [SW-1:0] side_ff  [QW];

   // one quotient bit per stage, restoring
   for (genvar k = 0; k < QW; k++) begin : g_step
      logic          cur_valid;
      logic [DW-1:0] cur_rem;
      logic [QW-1:0] cur_num;
      logic [DW-1:0] cur_div;
      logic [QW-1:0] cur_quo;
      logic [SW-1:0] cur_side;
      logic [DW:0]   trial;
      logic          take;

      if (k == 0) begin : g_head
         assign cur_valid = in_valid;
         assign cur_rem   = in_rem;
         assign cur_num   = in_num;
         assign cur_div   = in_div;
         assign cur_quo   = '0;
         assign cur_side  = in_side;
      end else begin : g_body
         assign cur_valid = valid_ff[k-1];
         assign cur_rem   = rem_ff[k-1];
         assign cur_num   = num_ff[k-1];
         assign cur_div   = div_ff[k-1];
         assign cur_quo   = quo_ff[k-1];
         assign cur_side  = side_ff[k-1];
      end

      assign trial = {cur_rem, cur_num[QW-1]};
      assign take  = trial >= {1'b0, cur_div};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= cur_valid;
         end
         rem_ff[k]  <= take ? DW'(trial - {1'b0, cur_div}) : trial[DW-1:0];
         num_ff[k]  <= cur_num << 1;
         div_ff[k]  <= cur_div;
         quo_ff[k]  <= {cur_quo[QW-2:0], take};
         side_ff[k] <= cur_side;
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

@@ rtl/core/cgf_sqrt.sv @@
module cgf_sqrt import cgf_pkg::*; #(
   parameter int RW = 66,
   parameter int SW = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [RW-1:0]      in_rad,
   input  logic [SW-1:0]      in_side,
   output logic               out_valid,
   output logic [RW/2-1:0]    out_root,
   output logic [SW-1:0]      out_side
);

   localparam int RTW  = RW / 2;
   localparam int REMW = RTW + 2;

   logic            valid_ff [RTW];
   logic [RW-1:0]   rad_ff   [RTW];
   logic [REMW-1:0] rem_ff   [RTW];
   logic [RTW-1:0]  root_ff  [RTW];
   logic [SW-1:0]   side_ff  [RTW];

   // one root bit per stage, two radicand bits brought down each time
   for (genvar k = 0; k < RTW; k++) begin : g_step
      logic            cur_valid;
      logic [RW-1:0]   cur_rad;
      logic [REMW-1:0] cur_rem;
      logic [RTW-1:0]  cur_root;
      logic [SW-1:0]   cur_side;
      logic [REMW-1:0] part;
      logic [REMW-1:0] trial;
      logic            take;

      if (k == 0) begin : g_head
         assign cur_valid = in_valid;
         assign cur_rad   = in_rad;
         assign cur_rem   = '0;
         assign cur_root  = '0;
         assign cur_side  = in_side;
      end else begin : g_body
         assign cur_valid = valid_ff[k-1];
         assign cur_rad   = rad_ff[k-1];
         assign cur_rem   = rem_ff[k-1];
         assign cur_root  = root_ff[k-1];
         assign cur_side  = side_ff[k-1];
      end

      assign part  = {cur_rem[REMW-3:0], cur_rad[RW-1:RW-2]};
      assign trial = {cur_root, 2'b01};
      assign take  = part >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= cur_valid;
         end
         rad_ff[k]  <= {cur_rad[RW-3:0], 2'b00};
         rem_ff[k]  <= take ? part - trial : part;
         root_ff[k] <= {cur_root[RTW-2:0], take};
         side_ff[k] <= cur_side;
      end
   end

   assign out_valid = valid_ff[RTW-1];
   assign out_root  = root_ff[RTW-1];
   assign out_side  = side_ff[RTW-1];

endmodule

@@ rtl/core/clamped_gravity_force.sv @@
// Pairwise 2D gravity in fixed point. One particle pair may be started in
// every cycle (busy never rises) and each pair gives one result word on
// rsp_valid; results come back in order and cannot be held off. A pair passes
// through the 64-stage magnitude divider, the 33-stage square root and the
// (FRAC_BITS+1)-stage unit-vector dividers in series, plus seven stages of
// differences, products, clamp and output saturation. Write the csr registers
// only while no pair is in flight.
module clamped_gravity_force import cgf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [WORD_W-1:0] req_pos_a_x,
   input  logic signed [WORD_W-1:0] req_pos_a_y,
   input  logic signed [WORD_W-1:0] req_pos_b_x,
   input  logic signed [WORD_W-1:0] req_pos_b_y,
   input  logic        [WORD_W-1:0] req_mass_a,
   input  logic        [WORD_W-1:0] req_mass_b,
   output logic                     rsp_valid,
   output logic signed [WORD_W-1:0] rsp_force_x,
   output logic signed [WORD_W-1:0] rsp_force_y,
   output logic                     rsp_saturated,
   input  logic                     csr_write_en,
   input  logic [1:0]               csr_index,
   input  logic [DIST_W-1:0]        csr_wdata
);

   localparam int NHW  = WORD_W - FRAC_BITS;
   localparam int UW   = FRAC_BITS + 1;
   localparam int PW   = 3 * WORD_W;
   localparam int MPW  = WORD_W + UW;
   localparam int FPW  = MAG_W + UW;
   localparam int QW   = MAG_W + 1;
   localparam int XW   = DIST_W + 24;

   // configuration registers
   logic [WORD_W-1:0] grav_ff;
   logic [DIST_W-1:0] min_ff;
   logic [DIST_W-1:0] max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff <= GRAV_RESET[WORD_W-1:0];
         min_ff  <= MIN_RESET;
         max_ff  <= MAX_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_GRAV_CONSTANT: grav_ff <= csr_wdata[WORD_W-1:0];
            CSR_MIN_DIST_SQ:   min_ff  <= csr_wdata;
            CSR_MAX_DIST_SQ:   max_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 1: offsets and g * mass_a
   logic                     s1_valid_ff;
   logic [DIFF_W-1:0]        s1_abs_x_ff, s1_abs_y_ff;
   logic                     s1_neg_x_ff, s1_neg_y_ff, s1_zero_ff;
   logic [2*WORD_W-1:0]      s1_gma_ff;
   logic [WORD_W-1:0]        s1_mb_ff;
   logic signed [DIFF_W-1:0] dx_in, dy_in;

   assign dx_in = DIFF_W'(req_pos_b_x) - DIFF_W'(req_pos_a_x);
   assign dy_in = DIFF_W'(req_pos_b_y) - DIFF_W'(req_pos_a_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_abs_x_ff <= dx_in[DIFF_W-1] ? DIFF_W'(-dx_in) : DIFF_W'(dx_in);
      s1_abs_y_ff <= dy_in[DIFF_W-1] ? DIFF_W'(-dy_in) : DIFF_W'(dy_in);
      s1_neg_x_ff <= dx_in[DIFF_W-1];
      s1_neg_y_ff <= dy_in[DIFF_W-1];
      s1_zero_ff  <= (dx_in == '0) && (dy_in == '0);
      s1_gma_ff   <= (2*WORD_W)'(grav_ff) * (2*WORD_W)'(req_mass_a);
      s1_mb_ff    <= req_mass_b;
   end

   // stage 2: squares and partial products of the mass term
   logic                 s2_valid_ff;
   logic [SQ_W-1:0]      s2_sx_ff, s2_sy_ff;
   logic [2*WORD_W-1:0]  s2_plo_ff, s2_phi_ff;
   logic [DIFF_W-1:0]    s2_abs_x_ff, s2_abs_y_ff;
   logic                 s2_neg_x_ff, s2_neg_y_ff, s2_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_sx_ff    <= SQ_W'(s1_abs_x_ff) * SQ_W'(s1_abs_x_ff);
      s2_sy_ff    <= SQ_W'(s1_abs_y_ff) * SQ_W'(s1_abs_y_ff);
      s2_plo_ff   <= (2*WORD_W)'(s1_gma_ff[WORD_W-1:0]) * (2*WORD_W)'(s1_mb_ff);
      s2_phi_ff   <= (2*WORD_W)'(s1_gma_ff[2*WORD_W-1:WORD_W]) * (2*WORD_W)'(s1_mb_ff);
      s2_abs_x_ff <= s1_abs_x_ff;
      s2_abs_y_ff <= s1_abs_y_ff;
      s2_neg_x_ff <= s1_neg_x_ff;
      s2_neg_y_ff <= s1_neg_y_ff;
      s2_zero_ff  <= s1_zero_ff;
   end

   // stage 3: squared length and full mass product
   logic               s3_valid_ff;
   logic [SQ_W-1:0]    s3_s_ff;
   logic [PW-1:0]      s3_p_ff;
   logic [DIFF_W-1:0]  s3_abs_x_ff, s3_abs_y_ff;
   logic               s3_neg_x_ff, s3_neg_y_ff, s3_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_s_ff     <= s2_sx_ff + s2_sy_ff;
      s3_p_ff     <= {s2_phi_ff, {WORD_W{1'b0}}} + PW'(s2_plo_ff);
      s3_abs_x_ff <= s2_abs_x_ff;
      s3_abs_y_ff <= s2_abs_y_ff;
      s3_neg_x_ff <= s2_neg_x_ff;
      s3_neg_y_ff <= s2_neg_y_ff;
      s3_zero_ff  <= s2_zero_ff;
   end

   // stage 4: scale, saturate and clamp the squared distance, split the mass product
   logic [XW-1:0]     d2_full;
   logic              d2_sat_in;
   logic [DIST_W-1:0] d2_in, c_lo_in;

   assign d2_full   = XW'(s3_s_ff) >> FRAC_BITS;
   assign d2_sat_in = |d2_full[XW-1:DIST_W];
   assign d2_in     = d2_sat_in ? {DIST_W{1'b1}} : d2_full[DIST_W-1:0];
   assign c_lo_in   = (d2_in < min_ff) ? min_ff : d2_in;

   logic               s4_valid_ff;
   logic [DIST_W-1:0]  s4_c_ff;
   logic [MAG_W-1:0]   s4_nl_ff;
   logic [NHW-1:0]     s4_nh_ff;
   logic [SQ_W-1:0]    s4_s_ff;
   logic [DIFF_W-1:0]  s4_abs_x_ff, s4_abs_y_ff;
   logic               s4_neg_x_ff, s4_neg_y_ff, s4_zero_ff, s4_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_c_ff     <= (c_lo_in > max_ff) ? max_ff : c_lo_in;
      s4_nl_ff    <= s3_p_ff[FRAC_BITS+MAG_W-1:FRAC_BITS];
      s4_nh_ff    <= s3_p_ff[PW-1:FRAC_BITS+MAG_W];
      s4_s_ff     <= s3_s_ff;
      s4_abs_x_ff <= s3_abs_x_ff;
      s4_abs_y_ff <= s3_abs_y_ff;
      s4_neg_x_ff <= s3_neg_x_ff;
      s4_neg_y_ff <= s3_neg_y_ff;
      s4_zero_ff  <= s3_zero_ff;
      s4_sat_ff   <= d2_sat_in;
   end

   // magnitude: g*ma*mb / (c * 2^F), overflow caught up front
   logic              mag_sat;
   mdiv_side_type     mdiv_side_in, mdiv_side_out;
   logic              mdiv_valid;
   logic [MAG_W-1:0]  mdiv_quo;

   assign mag_sat = (s4_c_ff == '0) || (DIST_W'(s4_nh_ff) >= s4_c_ff);

   always_comb begin
      mdiv_side_in.dist_sq = s4_s_ff;
      mdiv_side_in.abs_x   = s4_abs_x_ff;
      mdiv_side_in.abs_y   = s4_abs_y_ff;
      mdiv_side_in.neg_x   = s4_neg_x_ff;
      mdiv_side_in.neg_y   = s4_neg_y_ff;
      mdiv_side_in.zero    = s4_zero_ff;
      mdiv_side_in.sat     = s4_sat_ff || mag_sat;
      mdiv_side_in.mag_sat = mag_sat;
   end

   cgf_div #(
      .DW(DIST_W),
      .QW(MAG_W),
      .SW($bits(mdiv_side_type))
   ) u_mag_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s4_valid_ff),
      .in_rem   (mag_sat ? '0 : DIST_W'(s4_nh_ff)),
      .in_num   (s4_nl_ff),
      .in_div   (s4_c_ff),
      .in_side  (mdiv_side_in),
      .out_valid(mdiv_valid),
      .out_quo  (mdiv_quo),
      .out_side (mdiv_side_out)
   );

   // length of the unclamped offset
   sqrt_side_type     sqrt_side_in, sqrt_side_out;
   logic              sqrt_valid;
   logic [ROOT_W-1:0] len;

   always_comb begin
      sqrt_side_in.mag   = mdiv_side_out.mag_sat ? {MAG_W{1'b1}} : mdiv_quo;
      sqrt_side_in.abs_x = mdiv_side_out.abs_x;
      sqrt_side_in.abs_y = mdiv_side_out.abs_y;
      sqrt_side_in.neg_x = mdiv_side_out.neg_x;
      sqrt_side_in.neg_y = mdiv_side_out.neg_y;
      sqrt_side_in.zero  = mdiv_side_out.zero;
      sqrt_side_in.sat   = mdiv_side_out.sat;
   end

   cgf_sqrt #(
      .RW(SQ_W),
      .SW($bits(sqrt_side_type))
   ) u_len_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_valid (mdiv_valid),
      .in_rad   (mdiv_side_out.dist_sq),
      .in_side  (sqrt_side_in),
      .out_valid(sqrt_valid),
      .out_root (len),
      .out_side (sqrt_side_out)
   );

   // unit vector components: |d| * 2^F / len, below 2^(F+1)
   udiv_side_type  udiv_side_in, udiv_side_out;
   logic           ux_valid;
   logic [UW-1:0]  ux, uy;
   logic           uy_neg;
   logic           uy_valid;

   always_comb begin
      udiv_side_in.mag   = sqrt_side_out.mag;
      udiv_side_in.neg_x = sqrt_side_out.neg_x;
      udiv_side_in.zero  = sqrt_side_out.zero;
      udiv_side_in.sat   = sqrt_side_out.sat;
   end

   cgf_div #(
      .DW(ROOT_W),
      .QW(UW),
      .SW($bits(udiv_side_type))
   ) u_ux_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (sqrt_valid),
      .in_rem   (ROOT_W'(sqrt_side_out.abs_x[DIFF_W-1:1])),
      .in_num   ({sqrt_side_out.abs_x[0], {FRAC_BITS{1'b0}}}),
      .in_div   (len),
      .in_side  (udiv_side_in),
      .out_valid(ux_valid),
      .out_quo  (ux),
      .out_side (udiv_side_out)
   );

   cgf_div #(
      .DW(ROOT_W),
      .QW(UW),
      .SW(1)
   ) u_uy_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (sqrt_valid),
      .in_rem   (ROOT_W'(sqrt_side_out.abs_y[DIFF_W-1:1])),
      .in_num   ({sqrt_side_out.abs_y[0], {FRAC_BITS{1'b0}}}),
      .in_div   (len),
      .in_side  (sqrt_side_out.neg_y),
      .out_valid(uy_valid),
      .out_quo  (uy),
      .out_side (uy_neg)
   );

   // m1: magnitude halves times unit components
   logic            m1_valid_ff;
   logic [MPW-1:0]  m1_xlo_ff, m1_xhi_ff, m1_ylo_ff, m1_yhi_ff;
   logic            m1_neg_x_ff, m1_neg_y_ff, m1_zero_ff, m1_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= ux_valid && uy_valid;
      end
      m1_xlo_ff   <= MPW'(udiv_side_out.mag[WORD_W-1:0]) * MPW'(ux);
      m1_xhi_ff   <= MPW'(udiv_side_out.mag[MAG_W-1:WORD_W]) * MPW'(ux);
      m1_ylo_ff   <= MPW'(udiv_side_out.mag[WORD_W-1:0]) * MPW'(uy);
      m1_yhi_ff   <= MPW'(udiv_side_out.mag[MAG_W-1:WORD_W]) * MPW'(uy);
      m1_neg_x_ff <= udiv_side_out.neg_x;
      m1_neg_y_ff <= uy_neg;
      m1_zero_ff  <= udiv_side_out.zero;
      m1_sat_ff   <= udiv_side_out.sat;
   end

   // m2: join the halves and drop the fraction
   logic [FPW-1:0] fx_full, fy_full;
   logic           m2_valid_ff;
   logic [QW-1:0]  m2_qx_ff, m2_qy_ff;
   logic           m2_neg_x_ff, m2_neg_y_ff, m2_zero_ff, m2_sat_ff;

   assign fx_full = {m1_xhi_ff, {WORD_W{1'b0}}} + FPW'(m1_xlo_ff);
   assign fy_full = {m1_yhi_ff, {WORD_W{1'b0}}} + FPW'(m1_ylo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else begin
         m2_valid_ff <= m1_valid_ff;
      end
      m2_qx_ff    <= fx_full[FPW-1:FRAC_BITS];
      m2_qy_ff    <= fy_full[FPW-1:FRAC_BITS];
      m2_neg_x_ff <= m1_neg_x_ff;
      m2_neg_y_ff <= m1_neg_y_ff;
      m2_zero_ff  <= m1_zero_ff;
      m2_sat_ff   <= m1_sat_ff;
   end

   // m3: saturate, apply sign, zero for a zero offset, result word out
   logic [QW-1:0]     lim_x, lim_y;
   logic              sat_x, sat_y;
   logic [WORD_W-1:0] vx, vy;

   assign lim_x = m2_neg_x_ff ? QW'(33'h080000000) : QW'(33'h07FFFFFFF);
   assign lim_y = m2_neg_y_ff ? QW'(33'h080000000) : QW'(33'h07FFFFFFF);
   assign sat_x = m2_qx_ff > lim_x;
   assign sat_y = m2_qy_ff > lim_y;
   assign vx    = sat_x ? lim_x[WORD_W-1:0] : m2_qx_ff[WORD_W-1:0];
   assign vy    = sat_y ? lim_y[WORD_W-1:0] : m2_qy_ff[WORD_W-1:0];

   logic                     rsp_valid_ff;
   logic signed [WORD_W-1:0] force_x_ff, force_y_ff;
   logic                     saturated_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= m2_valid_ff;
      end
      if (m2_zero_ff) begin
         force_x_ff   <= '0;
         force_y_ff   <= '0;
         saturated_ff <= 1'b0;
      end else begin
         force_x_ff   <= m2_neg_x_ff ? -vx : vx;
         force_y_ff   <= m2_neg_y_ff ? -vy : vy;
         saturated_ff <= m2_sat_ff || sat_x || sat_y;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_force_x   = force_x_ff;
   assign rsp_force_y   = force_y_ff;
   assign rsp_saturated = saturated_ff;

endmodule

@@ tb/sv/cgf_checker.sv @@
`timescale 1ns / 1ps

module cgf_checker import cgf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic signed [WORD_W-1:0] req_pos_a_x,
   input  logic signed [WORD_W-1:0] req_pos_a_y,
   input  logic signed [WORD_W-1:0] req_pos_b_x,
   input  logic signed [WORD_W-1:0] req_pos_b_y,
   input  logic        [WORD_W-1:0] req_mass_a,
   input  logic        [WORD_W-1:0] req_mass_b,
   input  logic                     rsp_valid,
   input  logic signed [WORD_W-1:0] rsp_force_x,
   input  logic signed [WORD_W-1:0] rsp_force_y,
   input  logic                     rsp_saturated,
   input  logic                     csr_write_en,
   input  logic [1:0]               csr_index,
   input  logic [DIST_W-1:0]        csr_wdata,
   output int                       fail_count,
   output int                       pending
);

   localparam int FB = FRAC_BITS_DEF;

   typedef struct packed {
      logic [WORD_W-1:0] fx;
      logic [WORD_W-1:0] fy;
      logic              sat;
   } force_word_type;

   force_word_type     force_q[$];
   logic [WORD_W-1:0]  grav_ff;
   logic [DIST_W-1:0]  min_ff;
   logic [DIST_W-1:0]  max_ff;

   // scale one unit component by the magnitude, saturate, apply sign
   function automatic logic [WORD_W-1:0] scale_comp(logic [63:0] mag, logic [63:0] u,
                                                    logic neg, inout logic sat);
      logic [127:0] p;
      logic [127:0] lim;
      p   = ({64'd0, mag} * {64'd0, u}) >> FB;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (p > lim) begin
         p   = lim;
         sat = 1'b1;
      end
      return neg ? WORD_W'(-p) : WORD_W'(p);
   endfunction

   // expected force on particle a for one pair
   function automatic force_word_type gravity_force(logic signed [31:0] ax,
                                                    logic signed [31:0] ay,
                                                    logic signed [31:0] bx,
                                                    logic signed [31:0] by,
                                                    logic [31:0] ma, logic [31:0] mb);
      logic signed [33:0] dx, dy;
      logic [33:0]        adx, ady;
      logic [127:0]       s, d2, c, prod, mag, len, t, ux, uy;
      logic               sat;
      force_word_type     r;
      int                 b;
      dx  = 34'(bx) - 34'(ax);
      dy  = 34'(by) - 34'(ay);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      r   = '0;
      sat = 1'b0;
      if (adx == 0 && ady == 0) return r;
      s  = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
      d2 = s >> FB;
      if (d2 > 128'hFFFF_FFFF_FFFF) begin
         d2  = 128'hFFFF_FFFF_FFFF;
         sat = 1'b1;
      end
      c = d2 < min_ff ? 128'(min_ff) : d2;
      if (c > max_ff) c = 128'(max_ff);
      prod = 128'(grav_ff) * 128'(ma) * 128'(mb);
      if (c == 0) begin
         mag = {64'd0, {64{1'b1}}};
         sat = 1'b1;
      end else begin
         mag = prod / (c << FB);
         if (mag > {64'd0, {64{1'b1}}}) begin
            mag = {64'd0, {64{1'b1}}};
            sat = 1'b1;
         end
      end
      len = 0;
      for (b = 33; b >= 0; b--) begin
         t = len | (128'd1 << b);
         if (t * t <= s) len = t;
      end
      ux = (128'(adx) << FB) / len;
      uy = (128'(ady) << FB) / len;
      r.fx  = scale_comp(mag[63:0], ux[63:0], dx < 0, sat);
      r.fy  = scale_comp(mag[63:0], uy[63:0], dy < 0, sat);
      r.sat = sat;
      return r;
   endfunction

   always @(posedge clock) begin
      force_word_type exp_w;
      if (reset) begin
         grav_ff    <= WORD_W'(GRAV_RESET);
         min_ff     <= MIN_RESET;
         max_ff     <= MAX_RESET;
         fail_count <= 0;
         pending    <= 0;
         force_q.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_GRAV_CONSTANT: grav_ff <= csr_wdata[WORD_W-1:0];
               CSR_MIN_DIST_SQ:   min_ff  <= csr_wdata;
               CSR_MAX_DIST_SQ:   max_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy)
            force_q.push_back(gravity_force(req_pos_a_x, req_pos_a_y, req_pos_b_x,
                                            req_pos_b_y, req_mass_a, req_mass_b));
         // compare each word against the oldest prediction
         if (rsp_valid) begin
            if (force_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result word");
               fail_count <= fail_count + 1;
            end else begin
               exp_w = force_q.pop_front();
               if (exp_w.fx !== rsp_force_x || exp_w.fy !== rsp_force_y ||
                   exp_w.sat !== rsp_saturated) begin
                  if (fail_count < 10)
                     $display("mismatch: exp fx=%h fy=%h sat=%b got fx=%h fy=%h sat=%b",
                              exp_w.fx, exp_w.fy, exp_w.sat,
                              rsp_force_x, rsp_force_y, rsp_saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= force_q.size();
      end
   end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import cgf_pkg::*;;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic signed [WORD_W-1:0] req_pos_a_x = '0, req_pos_a_y = '0;
   logic signed [WORD_W-1:0] req_pos_b_x = '0, req_pos_b_y = '0;
   logic        [WORD_W-1:0] req_mass_a = '0, req_mass_b = '0;
   logic                     rsp_valid;
   logic signed [WORD_W-1:0] rsp_force_x, rsp_force_y;
   logic                     rsp_saturated;
   logic                     csr_write_en = 1'b0;
   logic [1:0]               csr_index = '0;
   logic [DIST_W-1:0]        csr_wdata = '0;
   int                       fail_count;
   int                       pending;
   int                       cycles = 0;
   int                       idle_pct = 0;

   localparam int LATENCY = 105 + FRAC_BITS_DEF;

   always #1 clock = ~clock;

   clamped_gravity_force uut (.*);

   cgf_checker chk (.*);

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 200000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [DIST_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // drain in-flight words before touching registers
   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // present one pair, with random idle cycles ahead of it
   task automatic send_pair(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                            logic [31:0] by, logic [31:0] ma, logic [31:0] mb);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_pos_a_x <= ax;
      req_pos_a_y <= ay;
      req_pos_b_x <= bx;
      req_pos_b_y <= by;
      req_mass_a  <= ma;
      req_mass_b  <= mb;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_pos();
      case ($urandom_range(4))
         0:       return $urandom();
         1:       return 32'($signed($urandom_range(2000)) - 1000) << 16;
         2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(600000)) - 300000);
      endcase
   endfunction

   function automatic logic [31:0] pick_mass();
      case ($urandom_range(3))
         0:       return $urandom();
         1:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
         default: return $urandom_range(32'h0010_0000);
      endcase
   endfunction

   task automatic random_pairs(int n);
      repeat (n) send_pair(pick_pos(), pick_pos(), pick_pos(), pick_pos(),
                           pick_mass(), pick_mass());
      start <= 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero offset, extremes, unit distance, clamp corners
      send_pair(0, 0, 0, 0, 32'h1_0000, 32'h1_0000);
      send_pair(32'h100, 32'h100, 32'h100, 32'h100, '1, '1);
      send_pair(0, 0, 32'h1_0000, 0, 32'h1_0000, 32'h1_0000);
      send_pair(0, 0, 0, 32'hFFFF_0000, 32'h1_0000, 32'h2_0000);
      send_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1);
      send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1, 1);
      send_pair(0, 0, 1, 0, '1, '1);
      send_pair(0, 0, 0, 1, 0, 32'h1_0000);
      send_pair(5, -7, -3, 9, 32'h3_0000, 32'h0_8000);
      send_pair(32'h10_0000, 0, 0, 32'h10_0000, 32'h100_0000, 32'h100_0000);
      start <= 1'b0;
      drain();

      // clamped distance zero, and minimum above maximum
      write_reg(CSR_MIN_DIST_SQ, '0);
      write_reg(CSR_MAX_DIST_SQ, '0);
      send_pair(0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000);
      start <= 1'b0;
      drain();
      write_reg(CSR_MIN_DIST_SQ, '1);
      write_reg(CSR_MAX_DIST_SQ, 48'h4_0000);
      write_reg(CSR_GRAV_CONSTANT, 48'hFFFF_FFFF);
      send_pair(0, 0, 32'h5_0000, 32'h3_0000, 32'h2_0000, 32'h1_0000);
      send_pair(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 1, 1);
      start <= 1'b0;
      drain();
      write_reg(CSR_GRAV_CONSTANT, '0);
      write_reg(2'd3, 48'h1234);
      send_pair(0, 0, 3, 4, '1, '1);
      start <= 1'b0;
      drain();

      // random phases: sender idles, then not, under several settings
      idle_pct = 23;
      write_reg(CSR_GRAV_CONSTANT, 48'h1_0000);
      write_reg(CSR_MIN_DIST_SQ, 48'h1_0000);
      write_reg(CSR_MAX_DIST_SQ, '1);
      random_pairs(250);
      drain();
      idle_pct = 54;
      write_reg(CSR_GRAV_CONSTANT, {16'd0, $urandom()});
      write_reg(CSR_MIN_DIST_SQ, DIST_W'({$urandom(), $urandom()}));
      write_reg(CSR_MAX_DIST_SQ, DIST_W'({$urandom(), $urandom()}));
      random_pairs(250);
      drain();
      idle_pct = 0;
      write_reg(CSR_GRAV_CONSTANT, 48'h0000_0100);
      write_reg(CSR_MIN_DIST_SQ, 48'h0);
      write_reg(CSR_MAX_DIST_SQ, 48'h0000_0FFF_FFFF);
      random_pairs(250);
      drain();

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
